[hdl/u8sf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u8sf_pkg: shared types and constants for the UTF-8 sanitizing filter
// Holds the byte codes, the code point limits and the beat and push
// structures that pass between the decoder, the output queue and the top.
// ----------------------------------------------------------------------------
package u8sf_pkg;

	// Byte classes.
	localparam logic [7:0] ASCII_PRINT_LO = 8'h20;
	localparam logic [7:0] ASCII_DEL      = 8'h7f;
	localparam logic [7:0] LEAD2_MASK     = 8'he0;
	localparam logic [7:0] LEAD2_CODE     = 8'hc0;
	localparam logic [7:0] LEAD3_MASK     = 8'hf0;
	localparam logic [7:0] LEAD3_CODE     = 8'he0;
	localparam logic [7:0] LEAD4_MASK     = 8'hf8;
	localparam logic [7:0] LEAD4_CODE     = 8'hf0;
	localparam logic [1:0] CONT_TAG       = 2'b10;

	// Sequence lengths; zero means no sequence is open.
	localparam logic [2:0] SEQ_NONE = 3'd0;
	localparam logic [2:0] SEQ_LEN2 = 3'd2;
	localparam logic [2:0] SEQ_LEN3 = 3'd3;
	localparam logic [2:0] SEQ_LEN4 = 3'd4;

	// Code point limits.
	localparam logic [20:0] CP_MIN2     = 21'h000080;
	localparam logic [20:0] CP_MIN3     = 21'h000800;
	localparam logic [20:0] CP_MIN4     = 21'h010000;
	localparam logic [20:0] CP_MAX      = 21'h10ffff;
	localparam logic [20:0] CP_SURR_LO  = 21'h00d800;
	localparam logic [20:0] CP_SURR_HI  = 21'h00dfff;

	// Output queue geometry.
	localparam int unsigned MAX_PUSH = 4;
	localparam int unsigned Q_DEPTH  = 8;
	localparam int unsigned Q_AW     = $clog2(Q_DEPTH);
	localparam int unsigned Q_CW     = $clog2(Q_DEPTH + 1);
	localparam int unsigned PUSH_CW  = $clog2(MAX_PUSH + 1);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} beat_t;

	typedef struct packed {
		logic [PUSH_CW-1:0]       n;
		beat_t [MAX_PUSH-1:0]     beat;
	} push_t;

endpackage : u8sf_pkg
`default_nettype wire

[hdl/u8sf_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u8sf_in_if: raw byte channel into the filter
// Valid/ready channel carrying one incoming byte and its end-of-text mark.
// ----------------------------------------------------------------------------
interface u8sf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;

	modport source (output valid, output in_byte, output end_of_text, input ready);
	modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface : u8sf_in_if
`default_nettype wire

[hdl/u8sf_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u8sf_out_if: sanitized byte channel out of the filter
// Valid/ready channel carrying one accepted byte and its end-of-run flag.
// ----------------------------------------------------------------------------
interface u8sf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface : u8sf_out_if
`default_nettype wire

[hdl/u8sf_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u8sf_decoder: sequence tracker and validator
// Holds the open multi-byte sequence and, for each accepted byte, decides
// which bytes are released, as one push of zero to four beats.
// ----------------------------------------------------------------------------
module u8sf_decoder (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  wire logic [7:0]     in_byte,
	input  wire logic           end_of_text,
	output u8sf_pkg::push_t     push
);
	import u8sf_pkg::*;

	logic [2:0]  len_q, len_n;
	logic [1:0]  cnt_q, cnt_n;
	logic [14:0] acc_q, acc_n;
	logic [7:0]  held_q [3];
	logic [7:0]  held_n [3];

	logic        seq_open;
	logic        is_cont;
	logic        completes;
	logic [20:0] cp;
	logic [20:0] shortest;
	logic        cp_ok;

	assign seq_open  = (len_q != SEQ_NONE);
	assign is_cont   = (in_byte[7:6] == CONT_TAG);
	assign cp        = {acc_q, in_byte[5:0]};
	assign completes = ({1'b0, cnt_q} + 3'd1) == len_q;

	always_comb begin
		unique case (len_q)
			SEQ_LEN2: shortest = CP_MIN2;
			SEQ_LEN3: shortest = CP_MIN3;
			default:  shortest = CP_MIN4;
		endcase
		cp_ok = (cp >= shortest) && (cp <= CP_MAX) &&
			!((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI));
	end

	always_comb begin
		push  = '0;
		len_n = len_q;
		cnt_n = cnt_q;
		acc_n = acc_q;
		for (int i = 0; i < 3; i++) begin
			held_n[i] = held_q[i];
		end

		if (seq_open && is_cont) begin
			if (completes) begin
				// The sequence is complete: release it whole or drop it.
				len_n = SEQ_NONE;
				cnt_n = 2'd0;
				acc_n = '0;
				if (cp_ok) begin
					for (int i = 0; i < 3; i++) begin
						push.beat[i] = '{data: held_q[i], last: 1'b0};
					end
					push.beat[len_q[1:0] - 2'd1] = '{data: in_byte, last: 1'b1};
					push.n = len_q;
				end
			end else begin
				held_n[cnt_q] = in_byte;
				cnt_n         = cnt_q + 2'd1;
				acc_n         = cp[14:0];
			end
		end else begin
			// Any open sequence is broken; the byte is handled afresh.
			len_n = SEQ_NONE;
			cnt_n = 2'd0;
			acc_n = '0;
			if (!in_byte[7]) begin
				if (in_byte >= ASCII_PRINT_LO && in_byte != ASCII_DEL) begin
					push.beat[0] = '{data: in_byte, last: 1'b1};
					push.n       = 3'd1;
				end
			end else if ((in_byte & LEAD2_MASK) == LEAD2_CODE) begin
				len_n     = SEQ_LEN2;
				cnt_n     = 2'd1;
				acc_n     = {10'd0, in_byte[4:0]};
				held_n[0] = in_byte;
			end else if ((in_byte & LEAD3_MASK) == LEAD3_CODE) begin
				len_n     = SEQ_LEN3;
				cnt_n     = 2'd1;
				acc_n     = {11'd0, in_byte[3:0]};
				held_n[0] = in_byte;
			end else if ((in_byte & LEAD4_MASK) == LEAD4_CODE) begin
				len_n     = SEQ_LEN4;
				cnt_n     = 2'd1;
				acc_n     = {12'd0, in_byte[2:0]};
				held_n[0] = in_byte;
			end
		end

		if (end_of_text) begin
			len_n = SEQ_NONE;
			cnt_n = 2'd0;
			acc_n = '0;
		end

		if (!fire) begin
			push.n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= SEQ_NONE;
			cnt_q <= 2'd0;
			acc_q <= '0;
		end else if (fire) begin
			len_q <= len_n;
			cnt_q <= cnt_n;
			acc_q <= acc_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < 3; i++) begin
				held_q[i] <= held_n[i];
			end
		end
	end

	// An open sequence always has its lead byte and is still short of its end.
	a_open_count: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q != SEQ_NONE) |-> (cnt_q != 2'd0) && ({1'b0, cnt_q} < len_q))
		else $error("open sequence with inconsistent byte count");

	// A multi-byte release always closes the sequence that produced it.
	a_release_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n >= 3'd2) |=> (len_q == SEQ_NONE))
		else $error("sequence still open after release");

	// Nothing is released without an accepted byte.
	a_push_needs_fire: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |-> (push.n == '0))
		else $error("push without accepted byte");

endmodule : u8sf_decoder
`default_nettype wire

[hdl/u8sf_outq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u8sf_outq: output beat queue
// Takes up to four beats per cycle and hands them out one per beat.
// ----------------------------------------------------------------------------
module u8sf_outq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire u8sf_pkg::push_t push,
	output logic                room,
	u8sf_out_if.source          tx
);
	import u8sf_pkg::*;

	beat_t           mem [Q_DEPTH];
	logic [Q_AW-1:0] wr_q, rd_q;
	logic [Q_CW-1:0] cnt_q;
	logic            pop;
	beat_t           head;

	assign room        = cnt_q <= Q_CW'(Q_DEPTH - MAX_PUSH);
	assign pop         = tx.valid && tx.ready;
	assign head        = mem[rd_q];
	assign tx.valid    = cnt_q != '0;
	assign tx.out_byte = head.data;
	assign tx.last_of_run = head.last;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_PUSH; i++) begin
			if (PUSH_CW'(i) < push.n) begin
				mem[wr_q + Q_AW'(i)] <= push.beat[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + Q_AW'(push.n);
			rd_q  <= rd_q + Q_AW'(pop);
			cnt_q <= cnt_q + Q_CW'(push.n) - Q_CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CW'(Q_DEPTH))
		else $error("output queue overflow");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != '0) |-> room)
		else $error("push while queue lacks room");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == '0 && !pop) |=> $stable(cnt_q))
		else $error("queue count moved without push or pop");

endmodule : u8sf_outq
`default_nettype wire

[hdl/utf8_sanitizing_filter.sv]
`default_nettype none
// A released beat is written into the output queue and is offered on tx behind any beats queued ahead of it.
// One input beat is accepted per cycle while the output queue has four free slots.
// A completed 2..4 byte sequence leaves as 2..4 output beats, one per cycle while tx is ready.
// Reset (arst_n low) closes any open sequence and empties the output queue.
// The eight-entry output queue sets how much output backlog is absorbed.
// ----------------------------------------------------------------------------
// utf8_sanitizing_filter: streaming UTF-8 sanitizer
// Passes printable ASCII and well-formed multi-byte UTF-8 sequences, and
// drops controls, DEL, stray continuation bytes, bad lead bytes, broken
// sequences, overlong forms, surrogates and values above U+10FFFF.
// ----------------------------------------------------------------------------
module utf8_sanitizing_filter (
	input  wire logic   clk,
	input  wire logic   arst_n,
	u8sf_in_if.sink     rx,
	u8sf_out_if.source  tx
);
	import u8sf_pkg::*;

	// The decoder works on a beat in the cycle it is accepted; its state
	// registers and the output queue are the only storage in the path.
	logic  room;
	logic  fire;
	push_t push;

	// Input is taken whenever the queue can absorb the largest possible
	// release, so a waiting output beat never blocks new input by itself.
	assign rx.ready = room;
	assign fire     = rx.valid && rx.ready;

	// The decoder tracks the open sequence and produces the beats that one
	// input byte releases: none, one ASCII byte, or a whole sequence.
	u8sf_decoder u_decoder (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.in_byte     (rx.in_byte),
		.end_of_text (rx.end_of_text),
		.push        (push)
	);

	// The queue serializes a multi-beat release onto the output channel.
	u8sf_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.tx     (tx)
	);

endmodule : utf8_sanitizing_filter
`default_nettype wire
